>>> rtl/kle_pkg.sv
// Shared types, constants and the scancode translation for the keyboard line editor.
`default_nettype none

package kle_pkg;

  // Default number of character cells in the line.
  localparam int LINE_DEPTH_DEF = 64;

  // Width of a cell position; covers every allowed line depth.
  localparam int CELL_IDX_W = 8;

  // Field widths.
  localparam int SCAN_W = 8;
  localparam int CHAR_W = 7;
  localparam int POS_W  = 6;
  localparam int KIND_W = 2;

  // Largest line length that the position fields can report.
  localparam int POS_MAX = 63;

  // Insert limit after reset.
  localparam logic [POS_W-1:0] INSERT_LIMIT_RST = 6'd62;

  // Scancodes handled outside the table.
  localparam logic [SCAN_W-1:0] CODE_LEFT  = 8'h4B;
  localparam logic [SCAN_W-1:0] CODE_RIGHT = 8'h4D;

  // Internal key codes.
  localparam logic [CHAR_W-1:0] CH_NONE      = 7'h00;
  localparam logic [CHAR_W-1:0] CH_LEFT      = 7'h01;
  localparam logic [CHAR_W-1:0] CH_RIGHT     = 7'h02;
  localparam logic [CHAR_W-1:0] CH_BACKSPACE = 7'h08;
  localparam logic [CHAR_W-1:0] CH_ENTER     = 7'h0A;
  localparam logic [CHAR_W-1:0] CH_PRINT_MIN = 7'h20;

  // Result kinds.
  localparam logic [KIND_W-1:0] KIND_STATUS = 2'd0;
  localparam logic [KIND_W-1:0] KIND_CMD    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_EMPTY  = 2'd2;

  // Scancode table, set 1 codes 0x00 to 0x39.
  localparam int KEY_TABLE_N = 58;
  localparam logic [CHAR_W-1:0] KEY_TABLE [KEY_TABLE_N] = '{
    7'h00, 7'h1B, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36,
    7'h37, 7'h38, 7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09,
    7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h79, 7'h75, 7'h69,
    7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h00, 7'h61, 7'h73,
    7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
    7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76,
    7'h62, 7'h6E, 7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h00,
    7'h00, 7'h20
  };

  // What every cell does with its stored character.
  typedef enum logic [1:0] {
    OP_HOLD   = 2'd0,
    OP_DEL    = 2'd1,
    OP_INS    = 2'd2,
    OP_STREAM = 2'd3
  } cell_op_t;

  // Command broadcast along the row of cells.
  typedef struct packed {
    cell_op_t          op;
    logic [POS_W-1:0]  pos;
    logic [CHAR_W-1:0] ch;
  } cell_cmd_t;

  // Translate a raw scancode into a key code; unmapped codes give CH_NONE.
  function automatic logic [CHAR_W-1:0] translate(input logic [SCAN_W-1:0] code);
    logic [CHAR_W-1:0] res;
    res = CH_NONE;
    if (code == CODE_LEFT) begin
      res = CH_LEFT;
    end else if (code == CODE_RIGHT) begin
      res = CH_RIGHT;
    end else if (code < SCAN_W'(KEY_TABLE_N)) begin
      res = KEY_TABLE[code[5:0]];
    end
    return res;
  endfunction

endpackage

`default_nettype wire

>>> rtl/kle_in_if.sv
// Scancode input channel with valid/ready transfer.
`default_nettype none

interface kle_in_if;
  logic                          valid;
  logic                          ready;
  logic [kle_pkg::SCAN_W-1:0]    scancode;

  modport source (output valid, output scancode, input ready);
  modport sink   (input valid, input scancode, output ready);
endinterface

`default_nettype wire

>>> rtl/kle_out_if.sv
// Result output channel with valid/ready transfer.
`default_nettype none

interface kle_out_if;
  logic                          valid;
  logic                          ready;
  logic [kle_pkg::KIND_W-1:0]    kind;
  logic [kle_pkg::CHAR_W-1:0]    char_code;
  logic [kle_pkg::POS_W-1:0]     cursor_index;
  logic [kle_pkg::POS_W-1:0]     line_length;
  logic                          last;

  modport source (output valid, output kind, output char_code, output cursor_index,
                  output line_length, output last, input ready);
  modport sink   (input valid, input kind, input char_code, input cursor_index,
                  input line_length, input last, output ready);
endinterface

`default_nettype wire

>>> rtl/kle_cell.sv
// One character cell of the line; moves data to or from its neighbors.
`default_nettype none

module kle_cell #(
  parameter int IDX = 0
) (
  input  wire                            clk,
  input  wire kle_pkg::cell_cmd_t        cmd,
  input  wire [kle_pkg::CHAR_W-1:0]      left_data,
  input  wire [kle_pkg::CHAR_W-1:0]      right_data,
  output logic [kle_pkg::CHAR_W-1:0]     data
);

  localparam logic [kle_pkg::CELL_IDX_W-1:0] MyIdx = kle_pkg::CELL_IDX_W'(IDX);

  logic [kle_pkg::CHAR_W-1:0]     data_r;
  logic [kle_pkg::CHAR_W-1:0]     data_nxt;
  logic [kle_pkg::CELL_IDX_W-1:0] pos_ext;

  assign pos_ext = kle_pkg::CELL_IDX_W'(cmd.pos);

  // Select the next character from this cell or a neighbor.
  always_comb begin
    data_nxt = data_r;
    case (cmd.op)
      kle_pkg::OP_HOLD: begin
        data_nxt = data_r;
      end
      kle_pkg::OP_DEL: begin
        if (MyIdx >= pos_ext) data_nxt = right_data;
      end
      kle_pkg::OP_INS: begin
        if (MyIdx > pos_ext) begin
          data_nxt = left_data;
        end else if (MyIdx == pos_ext) begin
          data_nxt = cmd.ch;
        end
      end
      kle_pkg::OP_STREAM: begin
        data_nxt = right_data;
      end
      default: begin
        data_nxt = data_r;
      end
    endcase
  end

  // Character storage; no reset, a cell is read only after it is written.
  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data = data_r;

endmodule

`default_nettype wire

>>> rtl/keyboard_line_editor_unit.sv
// Top level of the keyboard line editor: control, cell row and output register.
// The block takes set-1 scancodes and keeps an edit line held in a row of
// LINE_DEPTH character cells. A key that changes nothing visible, an arrow, a
// backspace or a printable character is handled in the cycle of its transfer
// and gives one status result; the cells shift in that same cycle. Enter gives
// one result per character, one per cycle while the output side takes them,
// by shifting the whole row toward cell zero; an empty line gives one result.
// A new scancode is taken when the block is not streaming a line and the
// output register is free or being emptied in that cycle. Unmapped codes
// and release codes are taken and dropped without a result. cfg_we writes
// the insert limit from cfg_wdata; the user must do so only while the block
// is idle, which the block itself does not enforce.
`default_nettype none

module keyboard_line_editor_unit #(
  parameter int LINE_DEPTH = kle_pkg::LINE_DEPTH_DEF
) (
  input  wire                          clk,
  input  wire                          rst_n,
  kle_in_if.sink                       in_ch,
  kle_out_if.source                    out_ch,
  input  wire                          cfg_we,
  input  wire [kle_pkg::POS_W-1:0]     cfg_wdata
);

  localparam int LineCap = ((LINE_DEPTH - 1) < kle_pkg::POS_MAX) ?
                           (LINE_DEPTH - 1) : kle_pkg::POS_MAX;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'b01,
    ST_STREAM = 2'b10
  } state_t;

  state_t                       state_r, state_nxt;
  logic [kle_pkg::POS_W-1:0]    cursor_r, cursor_nxt;
  logic [kle_pkg::POS_W-1:0]    len_r, len_nxt;
  logic [kle_pkg::POS_W-1:0]    rem_r, rem_nxt;
  logic [kle_pkg::POS_W-1:0]    limit_r;

  logic                         out_valid_r;
  logic [kle_pkg::KIND_W-1:0]   out_kind_r;
  logic [kle_pkg::CHAR_W-1:0]   out_char_r;
  logic [kle_pkg::POS_W-1:0]    out_cursor_r;
  logic [kle_pkg::POS_W-1:0]    out_len_r;
  logic                         out_last_r;

  logic                         out_load;
  logic [kle_pkg::KIND_W-1:0]   ld_kind;
  logic [kle_pkg::CHAR_W-1:0]   ld_char;
  logic [kle_pkg::POS_W-1:0]    ld_cursor;
  logic [kle_pkg::POS_W-1:0]    ld_len;
  logic                         ld_last;

  logic                         out_free;
  logic                         in_xfer;
  logic [kle_pkg::CHAR_W-1:0]   key;
  kle_pkg::cell_cmd_t           cmd;

  logic [kle_pkg::CHAR_W-1:0]   cell_q [LINE_DEPTH];

  assign out_free     = !out_valid_r || out_ch.ready;
  assign in_ch.ready  = (state_r == ST_IDLE) && out_free;
  assign in_xfer      = in_ch.valid && in_ch.ready;
  assign key          = kle_pkg::translate(in_ch.scancode);

  // Row of character cells; the ends see zero and their own data.
  for (genvar gi = 0; gi < LINE_DEPTH; gi++) begin : g_cell
    logic [kle_pkg::CHAR_W-1:0] left_d;
    logic [kle_pkg::CHAR_W-1:0] right_d;
    if (gi == 0) begin : g_first
      assign left_d = '0;
    end else begin : g_mid_l
      assign left_d = cell_q[gi-1];
    end
    if (gi == LINE_DEPTH - 1) begin : g_end
      assign right_d = cell_q[gi];
    end else begin : g_mid_r
      assign right_d = cell_q[gi+1];
    end
    kle_cell #(.IDX(gi)) u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .left_data  (left_d),
      .right_data (right_d),
      .data       (cell_q[gi])
    );
  end

  // Edit decisions, stream sequencing and the cell command.
  always_comb begin
    state_nxt  = state_r;
    cursor_nxt = cursor_r;
    len_nxt    = len_r;
    rem_nxt    = rem_r;
    cmd.op     = kle_pkg::OP_HOLD;
    cmd.pos    = cursor_r;
    cmd.ch     = key;
    out_load   = 1'b0;
    ld_kind    = kle_pkg::KIND_STATUS;
    ld_char    = '0;
    ld_cursor  = '0;
    ld_len     = '0;
    ld_last    = 1'b1;

    case (state_r)
      ST_IDLE: begin
        if (in_xfer && key != kle_pkg::CH_NONE) begin
          if (key == kle_pkg::CH_ENTER) begin
            cursor_nxt = '0;
            if (len_r == '0) begin
              out_load = 1'b1;
              ld_kind  = kle_pkg::KIND_EMPTY;
            end else begin
              state_nxt = ST_STREAM;
              rem_nxt   = len_r;
              len_nxt   = '0;
            end
          end else begin
            if (key == kle_pkg::CH_BACKSPACE) begin
              if (cursor_r != '0 && len_r != '0 && cursor_r <= len_r) begin
                cmd.op     = kle_pkg::OP_DEL;
                cmd.pos    = cursor_r - 1'b1;
                cursor_nxt = cursor_r - 1'b1;
                len_nxt    = len_r - 1'b1;
              end
            end else if (key == kle_pkg::CH_LEFT) begin
              if (cursor_r != '0) cursor_nxt = cursor_r - 1'b1;
            end else if (key == kle_pkg::CH_RIGHT) begin
              if (cursor_r < len_r) cursor_nxt = cursor_r + 1'b1;
            end else if (key >= kle_pkg::CH_PRINT_MIN) begin
              if (len_r < kle_pkg::POS_W'(LineCap) && cursor_r < limit_r &&
                  cursor_r <= len_r) begin
                cmd.op     = kle_pkg::OP_INS;
                cursor_nxt = cursor_r + 1'b1;
                len_nxt    = len_r + 1'b1;
              end
            end
            out_load  = 1'b1;
            ld_kind   = kle_pkg::KIND_STATUS;
            ld_cursor = cursor_nxt;
            ld_len    = len_nxt;
          end
        end
      end
      ST_STREAM: begin
        // Cell zero holds the next character; the row shifts toward it.
        if (out_free) begin
          out_load = 1'b1;
          ld_kind  = kle_pkg::KIND_CMD;
          ld_char  = cell_q[0];
          ld_last  = (rem_r == kle_pkg::POS_W'(1));
          cmd.op   = kle_pkg::OP_STREAM;
          rem_nxt  = rem_r - 1'b1;
          if (rem_r == kle_pkg::POS_W'(1)) state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control state and insert limit register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cursor_r    <= '0;
      len_r       <= '0;
      rem_r       <= '0;
      limit_r     <= kle_pkg::INSERT_LIMIT_RST;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cursor_r <= cursor_nxt;
      len_r    <= len_nxt;
      rem_r    <= rem_nxt;
      if (cfg_we) limit_r <= cfg_wdata;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Output payload register, loaded with each new result.
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_kind_r   <= ld_kind;
      out_char_r   <= ld_char;
      out_cursor_r <= ld_cursor;
      out_len_r    <= ld_len;
      out_last_r   <= ld_last;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.kind         = out_kind_r;
  assign out_ch.char_code    = out_char_r;
  assign out_ch.cursor_index = out_cursor_r;
  assign out_ch.line_length  = out_len_r;
  assign out_ch.last         = out_last_r;

endmodule

`default_nettype wire
